### rtl/depth_pixel_backprojection_assert.svh
// ----------------------------------------------------------------------------
// Depth pixel back-projection assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef DEPTH_PIXEL_BACKPROJECTION_ASSERT_SVH
`define DEPTH_PIXEL_BACKPROJECTION_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define DPB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("depth_pixel_backprojection check failed");

// Next-cycle implication, disabled while reset is held.
`define DPB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("depth_pixel_backprojection check failed");

`endif

### rtl/dpb_pkg.sv
// ----------------------------------------------------------------------------
// Depth pixel back-projection package
// Widths, register indexes, control types and offset finishing function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dpb_pkg;

    localparam int COORD_BITS  = 11;
    localparam int PIX_W       = 11;
    localparam int DEPTH_W     = 16;
    localparam int CENTER_W    = 12;
    localparam int INV_W       = 24;
    localparam int DIM_W       = 11;
    localparam int OFF_W       = 27;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int SCALE_SHIFT = 17;

    localparam int DIFF_W = (COORD_BITS + 1 > CENTER_W) ? COORD_BITS + 1 : CENTER_W;
    localparam int P1_W   = DEPTH_W + DIFF_W;
    localparam int MAG_W  = P1_W + INV_W;
    localparam int Q_W    = MAG_W - SCALE_SHIFT + 1;

    localparam logic [CENTER_W-1:0] CX_RESET  = CENTER_W'(639);
    localparam logic [CENTER_W-1:0] CY_RESET  = CENTER_W'(479);
    localparam logic [INV_W-1:0]    IFX_RESET = INV_W'(31957);
    localparam logic [INV_W-1:0]    IFY_RESET = INV_W'(31957);
    localparam logic [DIM_W-1:0]    W_RESET   = DIM_W'(640);
    localparam logic [DIM_W-1:0]    H_RESET   = DIM_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X     = 3'd0,
        CFG_CENTER_Y     = 3'd1,
        CFG_INV_FOCAL_X  = 3'd2,
        CFG_INV_FOCAL_Y  = 3'd3,
        CFG_IMAGE_WIDTH  = 3'd4,
        CFG_IMAGE_HEIGHT = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic capture;
        logic step1;
        logic step2;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic sample_nz;
    } t_dp_status;

    // Floor division by two to the scale shift, then saturation to the offset range.
    function automatic logic [OFF_W-1:0] f_finish(input logic neg,
                                                 input logic [MAG_W-1:0] mag);
        logic [Q_W-1:0]   q;
        logic [OFF_W-1:0] res;
        q = Q_W'(mag[MAG_W-1:SCALE_SHIFT])
            + Q_W'(neg && (mag[SCALE_SHIFT-1:0] != '0));
        if (neg) begin
            if (q > (Q_W'(1) << (OFF_W - 1))) begin
                res = {1'b1, {(OFF_W-1){1'b0}}};
            end else begin
                res = OFF_W'(~q + Q_W'(1));
            end
        end else begin
            if (q > Q_W'({1'b0, {(OFF_W-1){1'b1}}})) begin
                res = {1'b0, {(OFF_W-1){1'b1}}};
            end else begin
                res = OFF_W'(q);
            end
        end
        return res;
    endfunction

endpackage

### rtl/dpb_ctrl.sv
// ----------------------------------------------------------------------------
// Depth pixel back-projection controller
// Sequences capture, two multiply steps and output load (zero samples stop after capture); owns the handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpb_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  dpb_pkg::t_dp_status i_status,
    output dpb_pkg::t_dp_cmd    o_cmd
);
    import dpb_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        accept      = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                accept      = i_in_valid;
                o_cmd.capture = accept;
                if (accept && i_status.sample_nz) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.step1 = 1'b1;
                n_state     = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.step2 = 1'b1;
                n_state     = S_LOAD;
            end
            S_LOAD: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = (r_out_valid && !i_out_ready) || o_cmd.load;
    end

    assign o_out_valid = r_out_valid;

endmodule

### rtl/dpb_datapath.sv
// ----------------------------------------------------------------------------
// Depth pixel back-projection datapath
// Configuration, pixel counters, two-step products and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpb_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dpb_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [dpb_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [dpb_pkg::DEPTH_W-1:0]         i_depth_sample,
    input  dpb_pkg::t_dp_cmd                    i_cmd,
    output dpb_pkg::t_dp_status                 o_status,
    output logic [dpb_pkg::DEPTH_W-1:0]         o_forward_mm,
    output logic signed [dpb_pkg::OFF_W-1:0]    o_lateral_offset,
    output logic signed [dpb_pkg::OFF_W-1:0]    o_vertical_offset,
    output logic [dpb_pkg::PIX_W-1:0]           o_pixel_column,
    output logic [dpb_pkg::PIX_W-1:0]           o_pixel_row
);
    import dpb_pkg::*;

    logic [CENTER_W-1:0]   r_cx;
    logic [CENTER_W-1:0]   r_cy;
    logic [INV_W-1:0]      r_ifx;
    logic [INV_W-1:0]      r_ify;
    logic [DIM_W-1:0]      r_width;
    logic [DIM_W-1:0]      r_height;
    logic [COORD_BITS-1:0] r_col;
    logic [COORD_BITS-1:0] r_row;
    logic [COORD_BITS-1:0] n_col;
    logic [COORD_BITS-1:0] n_row;

    logic [DEPTH_W-1:0]    r_depth;
    logic [COORD_BITS-1:0] r_u;
    logic [COORD_BITS-1:0] r_v;
    logic                  r_neg_x;
    logic                  r_neg_y;
    logic [DIFF_W-1:0]     r_dx;
    logic [DIFF_W-1:0]     r_dy;
    logic [P1_W-1:0]       r_p1x;
    logic [P1_W-1:0]       r_p1y;
    logic [MAG_W-1:0]      r_p2x;
    logic [MAG_W-1:0]      r_p2y;

    logic [DEPTH_W-1:0]    r_fwd;
    logic [OFF_W-1:0]      r_lat;
    logic [OFF_W-1:0]      r_vert;
    logic [PIX_W-1:0]      r_pcol;
    logic [PIX_W-1:0]      r_prow;

    logic [DIFF_W-1:0]     twice_x;
    logic [DIFF_W-1:0]     twice_y;
    logic [DIFF_W-1:0]     cx_ext;
    logic [DIFF_W-1:0]     cy_ext;
    logic                  neg_x;
    logic                  neg_y;
    logic [COORD_BITS-1:0] col_inc;
    logic [COORD_BITS-1:0] row_inc;
    logic [DIM_W+COORD_BITS-1:0] col_cmp;
    logic [DIM_W+COORD_BITS-1:0] row_cmp;

    assign o_status.sample_nz = (i_depth_sample != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= CX_RESET;
            r_cy     <= CY_RESET;
            r_ifx    <= IFX_RESET;
            r_ify    <= IFY_RESET;
            r_width  <= W_RESET;
            r_height <= H_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_CENTER_X:     r_cx     <= i_cfg_data[CENTER_W-1:0];
                CFG_CENTER_Y:     r_cy     <= i_cfg_data[CENTER_W-1:0];
                CFG_INV_FOCAL_X:  r_ifx    <= i_cfg_data[INV_W-1:0];
                CFG_INV_FOCAL_Y:  r_ify    <= i_cfg_data[INV_W-1:0];
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        col_inc = r_col + COORD_BITS'(1);
        row_inc = r_row + COORD_BITS'(1);
        col_cmp = (DIM_W+COORD_BITS)'(col_inc);
        row_cmp = (DIM_W+COORD_BITS)'(row_inc);
        n_col   = col_inc;
        n_row   = r_row;
        if (col_cmp >= (DIM_W+COORD_BITS)'(r_width)) begin
            n_col = '0;
            n_row = row_inc;
            if (row_cmp >= (DIM_W+COORD_BITS)'(r_height)) begin
                n_row = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.capture) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_comb begin
        twice_x = DIFF_W'({r_col, 1'b0});
        twice_y = DIFF_W'({r_row, 1'b0});
        cx_ext  = DIFF_W'(r_cx);
        cy_ext  = DIFF_W'(r_cy);
        neg_x   = twice_x > cx_ext;
        neg_y   = twice_y > cy_ext;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_depth <= i_depth_sample;
            r_u     <= r_col;
            r_v     <= r_row;
            r_neg_x <= neg_x;
            r_neg_y <= neg_y;
            r_dx    <= neg_x ? (twice_x - cx_ext) : (cx_ext - twice_x);
            r_dy    <= neg_y ? (twice_y - cy_ext) : (cy_ext - twice_y);
        end
        if (i_cmd.step1) begin
            r_p1x <= P1_W'(r_depth) * P1_W'(r_dx);
            r_p1y <= P1_W'(r_depth) * P1_W'(r_dy);
        end
        if (i_cmd.step2) begin
            r_p2x <= MAG_W'(r_p1x) * MAG_W'(r_ifx);
            r_p2y <= MAG_W'(r_p1y) * MAG_W'(r_ify);
        end
        if (i_cmd.load) begin
            r_fwd  <= r_depth;
            r_lat  <= f_finish(r_neg_x, r_p2x);
            r_vert <= f_finish(r_neg_y, r_p2y);
            r_pcol <= PIX_W'(r_u);
            r_prow <= PIX_W'(r_v);
        end
    end

    assign o_forward_mm      = r_fwd;
    assign o_lateral_offset  = $signed(r_lat);
    assign o_vertical_offset = $signed(r_vert);
    assign o_pixel_column    = r_pcol;
    assign o_pixel_row       = r_prow;

endmodule

### rtl/depth_pixel_backprojection.sv
// A nonzero item is captured, takes the two multiply steps and is then loaded.
// Zero items: one per cycle while idle. A nonzero item keeps o_in_ready low until loaded.
// The load waits while an earlier result is still held; it then sets o_out_valid.
// A finished result waits in the output register while the next item is taken.
// Synchronous active-low reset restores the register defaults and zeroes the counters.
// ----------------------------------------------------------------------------
// Depth pixel back-projection top level
// Turns a raster depth stream into pinhole-model 3D points.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module depth_pixel_backprojection (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dpb_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [dpb_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [dpb_pkg::DEPTH_W-1:0]         i_depth_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [dpb_pkg::DEPTH_W-1:0]         o_forward_mm,
    output logic signed [dpb_pkg::OFF_W-1:0]    o_lateral_offset,
    output logic signed [dpb_pkg::OFF_W-1:0]    o_vertical_offset,
    output logic [dpb_pkg::PIX_W-1:0]           o_pixel_column,
    output logic [dpb_pkg::PIX_W-1:0]           o_pixel_row
);
    import dpb_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    dpb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    dpb_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_depth_sample    (i_depth_sample),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_forward_mm      (o_forward_mm),
        .o_lateral_offset  (o_lateral_offset),
        .o_vertical_offset (o_vertical_offset),
        .o_pixel_column    (o_pixel_column),
        .o_pixel_row       (o_pixel_row)
    );

endmodule

### rtl/dpb_checker.sv
// ----------------------------------------------------------------------------
// Depth pixel back-projection checker
// Port-level checks on results and handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "depth_pixel_backprojection_assert.svh"

module dpb_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_ready,
    input  logic [dpb_pkg::DEPTH_W-1:0]         i_depth_sample,
    input  logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  logic [dpb_pkg::DEPTH_W-1:0]         o_forward_mm,
    input  logic signed [dpb_pkg::OFF_W-1:0]    o_lateral_offset,
    input  logic signed [dpb_pkg::OFF_W-1:0]    o_vertical_offset,
    input  logic [dpb_pkg::PIX_W-1:0]           o_pixel_column,
    input  logic [dpb_pkg::PIX_W-1:0]           o_pixel_row
);
    import dpb_pkg::*;

    logic nz_accept;
    logic col_max;
    logic [DEPTH_W+2*OFF_W+2*PIX_W-1:0] out_bits;

    assign nz_accept = i_in_valid && o_in_ready && (i_depth_sample != '0);
    assign col_max   = (o_pixel_column == {PIX_W{1'b1}});
    assign out_bits  = {o_forward_mm, o_lateral_offset, o_vertical_offset,
                        o_pixel_column, o_pixel_row};

    `DPB_ASSERT_NOW(a_result_nonzero, o_out_valid, o_forward_mm != '0)
    `DPB_ASSERT_NOW(a_column_in_range, o_out_valid, !col_max)
    `DPB_ASSERT_NEXT(a_busy_after_point, nz_accept, !o_in_ready)
    `DPB_ASSERT_NEXT(a_result_held, o_out_valid && !i_out_ready, o_out_valid && $stable(out_bits))

endmodule

bind depth_pixel_backprojection dpb_checker u_checker (.*);

### tb/tb_depth_pixel_backprojection.sv
// ----------------------------------------------------------------------------
// Depth pixel back-projection testbench
// Streams depth items through the block under several camera settings and
// idle patterns, predicts every 3D point and compares each result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_depth_pixel_backprojection;

    import dpb_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT = 10;
    localparam logic [OFF_W-1:0] OFFSET_MAX = {1'b0, {(OFF_W-1){1'b1}}};
    localparam logic [OFF_W-1:0] OFFSET_MIN = {1'b1, {(OFF_W-1){1'b0}}};
    localparam int SEND_IDLE_PCT [4] = '{0, 74, 0, 32};
    localparam int STALL_PCT [4] = '{0, 0, 74, 32};
    localparam logic [DEPTH_W-1:0] CORNER_DEPTHS [0:19] = '{
        16'd0, 16'd1, 16'hFFFF, 16'h5555, 16'hAAAA, 16'd0, 16'd0, 16'h8000,
        16'h7FFF, 16'd2, 16'h00FF, 16'hFF00, 16'd0, 16'h0F0F, 16'hF0F0,
        16'd1000, 16'hFFFE, 16'd0, 16'd3000, 16'hFFFF
    };

    typedef struct packed {
        logic [DEPTH_W-1:0] fwd;
        logic [OFF_W-1:0]   lat;
        logic [OFF_W-1:0]   vert;
        logic [PIX_W-1:0]   col;
        logic [PIX_W-1:0]   row;
    } t_point;

    class t_point_board;
        logic [CENTER_W-1:0]   cx_half;
        logic [CENTER_W-1:0]   cy_half;
        logic [INV_W-1:0]      inv_fx;
        logic [INV_W-1:0]      inv_fy;
        logic [DIM_W-1:0]      width;
        logic [DIM_W-1:0]      height;
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        t_point                expected_q[$];
        int                    errors;

        function new();
            cx_half = 12'd639;
            cy_half = 12'd479;
            inv_fx = 24'd31957;
            inv_fy = 24'd31957;
            width = 11'd640;
            height = 11'd480;
            col = '0;
            row = '0;
            errors = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_CENTER_X:     cx_half = val[CENTER_W-1:0];
                CFG_CENTER_Y:     cy_half = val[CENTER_W-1:0];
                CFG_INV_FOCAL_X:  inv_fx = val[INV_W-1:0];
                CFG_INV_FOCAL_Y:  inv_fy = val[INV_W-1:0];
                CFG_IMAGE_WIDTH:  width = val[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: height = val[DIM_W-1:0];
                default: ;
            endcase
        endfunction

        // Floor of depth * (center_half - 2 * pos) * inv / 2^17, saturated.
        function logic [OFF_W-1:0] offset_q8(logic [DEPTH_W-1:0] depth,
                                             logic [CENTER_W-1:0] center,
                                             logic [COORD_BITS-1:0] pos,
                                             logic [INV_W-1:0] inv);
            logic [CENTER_W:0] twice;
            logic [CENTER_W:0] diff;
            logic [63:0]       mag;
            logic [63:0]       q;
            logic              neg;
            twice = {pos, 1'b0};
            neg = twice > {1'b0, center};
            diff = neg ? twice - {1'b0, center} : {1'b0, center} - twice;
            mag = 64'(depth) * 64'(diff) * 64'(inv);
            if (neg) begin
                q = (mag + 64'h1FFFF) >> SCALE_SHIFT;
                return (q > 64'd67108864) ? OFFSET_MIN : OFF_W'(64'd0 - q);
            end
            q = mag >> SCALE_SHIFT;
            return (q > 64'(OFFSET_MAX)) ? OFFSET_MAX : OFF_W'(q);
        endfunction

        function void note_sample(logic [DEPTH_W-1:0] depth);
            t_point                p;
            logic [COORD_BITS-1:0] nc;
            logic [COORD_BITS-1:0] nr;
            if (depth != '0) begin
                p.fwd = depth;
                p.lat = offset_q8(depth, cx_half, col, inv_fx);
                p.vert = offset_q8(depth, cy_half, row, inv_fy);
                p.col = PIX_W'(col);
                p.row = PIX_W'(row);
                expected_q.insert(expected_q.size(), p);
            end
            nc = col + 1'b1;
            nr = row;
            if (32'(nc) >= 32'(width)) begin
                nc = '0;
                nr = row + 1'b1;
                if (32'(nr) >= 32'(height)) begin
                    nr = '0;
                end
            end
            col = nc;
            row = nr;
        endfunction

        function void check_point(t_point got);
            t_point want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("Unexpected point at column %0d row %0d with forward %0d.",
                             got.col, got.row, got.fwd);
                end
                return;
            end
            want = expected_q.pop_front();
            if (want.fwd !== got.fwd || want.lat !== got.lat || want.vert !== got.vert
                    || want.col !== got.col || want.row !== got.row) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("Point mismatch, expected fwd %0d lat %0d vert %0d col %0d row %0d",
                             want.fwd, $signed(want.lat), $signed(want.vert),
                             want.col, want.row);
                    $display("                  actual fwd %0d lat %0d vert %0d col %0d row %0d",
                             got.fwd, $signed(got.lat), $signed(got.vert), got.col, got.row);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [DEPTH_W-1:0]      i_depth_sample;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic [DEPTH_W-1:0]      o_forward_mm;
    logic signed [OFF_W-1:0] o_lateral_offset;
    logic signed [OFF_W-1:0] o_vertical_offset;
    logic [PIX_W-1:0]        o_pixel_column;
    logic [PIX_W-1:0]        o_pixel_row;

    t_point_board board;
    int           send_idle_pct = 0;
    int           stall_pct = 0;
    int unsigned  cycle_count = 0;

    depth_pixel_backprojection dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_depth_sample    (i_depth_sample),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_forward_mm      (o_forward_mm),
        .o_lateral_offset  (o_lateral_offset),
        .o_vertical_offset (o_vertical_offset),
        .o_pixel_column    (o_pixel_column),
        .o_pixel_row       (o_pixel_row)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_depth_pixel_backprojection failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_point({o_forward_mm, o_lateral_offset, o_vertical_offset,
                               o_pixel_column, o_pixel_row});
        end
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic set_pace(input int mode);
        send_idle_pct = SEND_IDLE_PCT[mode % 4];
        stall_pct = STALL_PCT[mode % 4];
    endtask

    task automatic send_depth(input logic [DEPTH_W-1:0] depth);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_depth_sample <= depth;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_sample(depth);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val,
                             input bit last);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        board.set_reg(idx, val);
        if (last) begin
            i_cfg_we <= 1'b0;
        end
    endtask

    // Unused upper data bits carry random junk that the block must ignore.
    task automatic program_camera(input logic [CENTER_W-1:0] cx, input logic [CENTER_W-1:0] cy,
                                  input logic [INV_W-1:0] ifx, input logic [INV_W-1:0] ify,
                                  input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        write_reg(CFG_CENTER_X, {12'($urandom), cx}, 1'b0);
        write_reg(CFG_CENTER_Y, {12'($urandom), cy}, 1'b0);
        write_reg(CFG_INV_FOCAL_X, ifx, 1'b0);
        write_reg(CFG_INV_FOCAL_Y, ify, 1'b0);
        write_reg(CFG_IMAGE_WIDTH, {13'($urandom), w}, 1'b0);
        write_reg(CFG_IMAGE_HEIGHT, {13'($urandom), h}, 1'b1);
    endtask

    function automatic logic [DEPTH_W-1:0] random_depth();
        case ($urandom_range(9))
            0, 1:    return '0;
            2:       return 16'd1;
            3:       return 16'hFFFF;
            4:       return DEPTH_W'($urandom_range(1, 255));
            default: return DEPTH_W'($urandom);
        endcase
    endfunction

    function automatic logic [INV_W-1:0] random_inv();
        case ($urandom_range(3))
            0:       return INV_W'($urandom_range(1, 255));
            1:       return INV_W'($urandom_range(16000, 70000));
            2:       return INV_W'($urandom);
            default: return 24'hFFFFFF >> $urandom_range(0, 23);
        endcase
    endfunction

    initial begin
        int k;
        int phase;
        board = new();
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_depth_sample <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default camera straight out of reset.
        set_pace(0);
        for (k = 0; k < 20; k++) begin
            send_depth(CORNER_DEPTHS[k]);
        end
        settle();

        // Large positive lateral offsets saturate; vertical ones are zero on row 0, negative below.
        set_pace(1);
        program_camera(12'd4095, 12'd0, 24'hFFFFFF, 24'hFFFFFF, 11'd5, 11'd3);
        for (k = 0; k < 30; k++) begin
            send_depth((k % 5 == 0) ? 16'hFFFF : random_depth());
        end
        settle();

        // Zero dimensions pin the counters and zero reciprocals clear the offsets.
        set_pace(2);
        program_camera(12'd0, 12'd4095, 24'd0, 24'd0, 11'd0, 11'd0);
        for (k = 0; k < 20; k++) begin
            send_depth(random_depth());
        end
        settle();

        set_pace(3);
        program_camera(12'd0, 12'd0, 24'd1, 24'd1, 11'd1, 11'd1);
        for (k = 0; k < 20; k++) begin
            send_depth(random_depth());
        end
        settle();

        // Shrink the image mid-frame so the counters sit beyond the new size.
        set_pace(1);
        program_camera(12'($urandom), 12'($urandom), random_inv(), random_inv(), 11'd10, 11'd10);
        for (k = 0; k < 37; k++) begin
            send_depth(random_depth());
        end
        settle();
        set_pace(3);
        program_camera(board.cx_half, board.cy_half, board.inv_fx, board.inv_fy, 11'd3, 11'd2);
        for (k = 0; k < 20; k++) begin
            send_depth(random_depth());
        end
        settle();

        for (phase = 0; phase < 8; phase++) begin
            set_pace(phase);
            program_camera(12'($urandom), 12'($urandom), random_inv(), random_inv(),
                           ($urandom_range(7) == 0) ? DIM_W'($urandom_range(1, 2047))
                                                    : DIM_W'($urandom_range(1, 12)),
                           DIM_W'($urandom_range(1, 8)));
            for (k = 0; k < 63; k++) begin
                send_depth(random_depth());
            end
            settle();
        end

        if (board.errors == 0 && board.pending() == 0) begin
            $display("tb_depth_pixel_backprojection passed");
        end else begin
            $display("tb_depth_pixel_backprojection failed");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/dpb_pkg.sv
rtl/dpb_ctrl.sv
rtl/dpb_datapath.sv
rtl/depth_pixel_backprojection.sv
rtl/dpb_checker.sv
tb/tb_depth_pixel_backprojection.sv
